// File: design/bts_pkg.sv
// bts_pkg: shared constants, types and lane blend for the bilinear texel sampler
`timescale 1ns / 1ps

package bts_pkg;

   // sheet storage
   localparam int SHEET_WORDS = 262144;
   localparam int SHEET_AW    = $clog2(SHEET_WORDS);
   localparam int WORD_W      = 32;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;

   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_CODE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT_CODE    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_X       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_Y       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE_FLAGS     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHEET_SWAP     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_DETAIL_ORIGIN  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_DETAIL_MIN_LOD = 3'd7;

   // mode flag bits
   localparam int MODE_MIRROR_X = 0;
   localparam int MODE_MIRROR_Y = 1;
   localparam int MODE_WRAP_X   = 2;
   localparam int MODE_WRAP_Y   = 3;
   localparam int MODE_TRANSL   = 4;

   // request kinds
   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   // texel lanes
   localparam logic [23:0] LANE_MASK       = 24'hff00ff;
   localparam logic [23:0] OPAQUE_TAG      = 24'h800000;
   localparam logic [23:0] TEXEL_CLEAR     = 24'h0000f0;
   localparam logic [8:0]  FRAC_HALF       = 9'h080;
   localparam logic [8:0]  FRAC_ONE        = 9'h100;

   // one memory access in flight, waiting for its read data
   typedef struct packed {
      logic       last;
      logic       write;
      logic       sheet_b;
      logic [1:0] step;
      logic [2:0] nib;
      logic       hit;
      logic [8:0] uf;
      logic [8:0] vf;
      logic       transl;
   } pend_type;

   // x + ((y - x) * a >> 8) on two 8-bit lanes sixteen bits apart, 32-bit wrap
   function automatic logic [23:0] blend_lanes(input logic [23:0] x, input logic [23:0] y,
                                               input logic [8:0] a);
      logic [31:0] diff;
      logic [31:0] prod;
      logic [31:0] sum;
      diff = 32'(y) - 32'(x);
      prod = diff * 32'(a);
      sum  = 32'(x) + (prod >> 8);
      return sum[23:0] & LANE_MASK;
   endfunction

endpackage

// File: design/bilinear_texel_sampler.sv
// bilinear_texel_sampler: texture sheet store and bilinear sampler over 4-bit texels
`timescale 1ns / 1ps

// Requests enter on the req_ valid/ready channel. A write beat stores one 32-bit word
// into sheet a or b; a sample beat has mip level and u, v as signed 24.8 fixed point.
// Each request gives exactly one rsp_ beat, in request order: 0 for a write, the
// blended texel for a sample. Registers are set through csr_we/csr_index/csr_wdata;
// the user must write them only while the block is idle, as the block does not enforce it.
// A sample holds the issue stage for four steps, one per texel read on the single
// port of the sheet memory; a write holds it for a single step. From acceptance
// to rsp_valid a request passes issue, memory read, first lerp pair and second
// lerp into the output register.
// A new request is taken in the cycle the previous one finishes issuing, even while
// a result waits in the output register. At most two finished requests are held
// past the issue stage; when rsp_ready stays low the issue stage waits and then
// req_ready drops. Reset clears the configuration registers and the pipeline but
// not the sheets, whose words must be written before they are sampled.

module bilinear_texel_sampler (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic                              req_sheet_sel,
   input  logic [17:0]                       req_word_addr,
   input  logic [31:0]                       req_word_data,
   input  logic signed [3:0]                 req_mip_level,
   input  logic signed [31:0]                req_u_coord,
   input  logic signed [31:0]                req_v_coord,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [23:0]                       rsp_texel_value,

   input  logic                              csr_we,
   input  logic [bts_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bts_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import bts_pkg::*;

   // configuration
   logic [2:0]  width_code_ff, width_code_in;
   logic [2:0]  height_code_ff, height_code_in;
   logic [10:0] origin_x_ff, origin_x_in;
   logic [9:0]  origin_y_ff, origin_y_in;
   logic [4:0]  mode_flags_ff, mode_flags_in;
   logic        sheet_swap_ff, sheet_swap_in;
   logic [2:0]  detail_origin_ff, detail_origin_in;
   logic [1:0]  detail_min_lod_ff, detail_min_lod_in;

   always_comb begin
      width_code_in     = width_code_ff;
      height_code_in    = height_code_ff;
      origin_x_in       = origin_x_ff;
      origin_y_in       = origin_y_ff;
      mode_flags_in     = mode_flags_ff;
      sheet_swap_in     = sheet_swap_ff;
      detail_origin_in  = detail_origin_ff;
      detail_min_lod_in = detail_min_lod_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_WIDTH_CODE:     width_code_in     = csr_wdata[2:0];
            CSR_HEIGHT_CODE:    height_code_in    = csr_wdata[2:0];
            CSR_ORIGIN_X:       origin_x_in       = csr_wdata[10:0];
            CSR_ORIGIN_Y:       origin_y_in       = csr_wdata[9:0];
            CSR_MODE_FLAGS:     mode_flags_in     = csr_wdata[4:0];
            CSR_SHEET_SWAP:     sheet_swap_in     = csr_wdata[0];
            CSR_DETAIL_ORIGIN:  detail_origin_in  = csr_wdata[2:0];
            CSR_DETAIL_MIN_LOD: detail_min_lod_in = csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_code_ff     <= '0;
         height_code_ff    <= '0;
         origin_x_ff       <= '0;
         origin_y_ff       <= '0;
         mode_flags_ff     <= '0;
         sheet_swap_ff     <= 1'b0;
         detail_origin_ff  <= '0;
         detail_min_lod_ff <= '0;
      end else begin
         width_code_ff     <= width_code_in;
         height_code_ff    <= height_code_in;
         origin_x_ff       <= origin_x_in;
         origin_y_ff       <= origin_y_in;
         mode_flags_ff     <= mode_flags_in;
         sheet_swap_ff     <= sheet_swap_in;
         detail_origin_ff  <= detail_origin_in;
         detail_min_lod_ff <= detail_min_lod_in;
      end
   end

   // ---------------------------------------------------------------- setup
   logic        req_fire;
   logic        s_detail;
   logic [2:0]  s_lv;
   logic [31:0] s_u_raw, s_v_raw;
   logic [31:0] s_u, s_v;
   logic [4:0]  s_w_sum, s_h_sum;
   logic [3:0]  s_tw_log, s_th_log;
   logic [11:0] s_mask_u, s_mask_v;
   logic [31:0] s_ox_ext, s_oy_ext;

   logic [11:0] iss_u0_in, iss_u1_in, iss_v0_in, iss_v1_in;
   logic [8:0]  iss_uf_in, iss_vf_in;
   logic [10:0] iss_tx_in;
   logic [9:0]  iss_ty_in;
   logic        iss_sheet_b_in;

   assign s_u_raw = req_u_coord;
   assign s_v_raw = req_v_coord;
   assign s_w_sum = 5'(width_code_ff) + 5'd5;
   assign s_h_sum = 5'(height_code_ff) + 5'd5;

   always_comb begin
      s_detail = req_mip_level[3];
      s_lv     = req_mip_level[2:0];
      s_ox_ext = {21'h1fffff, origin_x_ff} >> s_lv;
      s_oy_ext = {22'h3fffff, origin_y_ff} >> s_lv;
      if (s_detail) begin
         s_u       = s_u_raw << (4'd1 << detail_min_lod_ff);
         s_v       = s_v_raw << (4'd1 << detail_min_lod_ff);
         s_tw_log  = 4'd7;
         s_th_log  = 4'd7;
         iss_tx_in = detail_origin_ff[0] ? 11'd128 : 11'd0;
         iss_ty_in = {1'b0, detail_origin_ff[2:1], 7'd0};
      end else begin
         s_u       = 32'(req_u_coord >>> s_lv);
         s_v       = 32'(req_v_coord >>> s_lv);
         // a level that would shrink a side below two texels keeps two
         s_tw_log  = (s_w_sum > 5'(s_lv)) ? 4'(s_w_sum - 5'(s_lv)) : 4'd1;
         s_th_log  = (s_h_sum > 5'(s_lv)) ? 4'(s_h_sum - 5'(s_lv)) : 4'd1;
         iss_tx_in = s_ox_ext[10:0];
         iss_ty_in = s_oy_ext[9:0];
      end
      iss_sheet_b_in = (s_detail | s_lv[0]) ^ sheet_swap_ff;
      s_mask_u = ~(12'hfff << s_tw_log);
      s_mask_v = ~(12'hfff << s_th_log);

      if (mode_flags_ff[MODE_MIRROR_X] && s_u[s_tw_log + 5'd8]) begin
         s_u = ~s_u;
      end
      if (mode_flags_ff[MODE_MIRROR_Y] && s_v[s_th_log + 5'd8]) begin
         s_v = ~s_v;
      end
      s_u = s_u - 32'h80;
      s_v = s_v - 32'h80;

      iss_uf_in = {1'b0, s_u[7:0]};
      iss_vf_in = {1'b0, s_v[7:0]};
      iss_u0_in = s_u[19:8] & s_mask_u;
      iss_u1_in = (iss_u0_in + 12'd1) & s_mask_u;
      iss_v0_in = s_v[19:8] & s_mask_v;
      iss_v1_in = (iss_v0_in + 12'd1) & s_mask_v;

      // edge clamp: the far edge pairs the last two texels or the first two
      if (!mode_flags_ff[MODE_WRAP_X] && iss_u1_in == 12'd0) begin
         if (iss_uf_in >= FRAC_HALF) begin
            iss_u0_in = 12'd0;
            iss_u1_in = 12'd1;
            iss_uf_in = 9'd0;
         end else begin
            iss_u1_in = iss_u0_in;
            iss_u0_in = iss_u0_in - 12'd1;
            iss_uf_in = FRAC_ONE;
         end
      end
      if (!mode_flags_ff[MODE_WRAP_Y] && iss_v1_in == 12'd0) begin
         if (iss_vf_in >= FRAC_HALF) begin
            iss_v0_in = 12'd0;
            iss_v1_in = 12'd1;
            iss_vf_in = 9'd0;
         end else begin
            iss_v1_in = iss_v0_in;
            iss_v0_in = iss_v0_in - 12'd1;
            iss_vf_in = FRAC_ONE;
         end
      end
   end

   // ---------------------------------------------------------------- issue stage
   logic        iss_valid_ff, iss_valid_in;
   logic [1:0]  iss_step_ff, iss_step_in;
   logic        iss_write_ff;
   logic        iss_wsheet_ff;
   logic [17:0] iss_addr_ff;
   logic [31:0] iss_data_ff;
   logic        iss_sheet_b_ff;
   logic        iss_transl_ff;
   logic [11:0] iss_u0_ff, iss_u1_ff, iss_v0_ff, iss_v1_ff;
   logic [8:0]  iss_uf_ff, iss_vf_ff;
   logic [10:0] iss_tx_ff;
   logic [9:0]  iss_ty_ff;

   logic [1:0]  cnt_ff, cnt_in;
   logic        rsp_fire;
   logic        iss_last;
   logic        iss_fire;
   logic        credit_ok;

   assign rsp_fire  = rsp_valid && rsp_ready;
   assign credit_ok = (cnt_ff < 2'd2) || rsp_fire;
   assign iss_last  = (iss_write_ff == REQ_WRITE) || (iss_step_ff == 2'd3);
   assign iss_fire  = iss_valid_ff && (!iss_last || credit_ok);
   assign req_ready = !iss_valid_ff || (iss_fire && iss_last);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      iss_valid_in = iss_valid_ff;
      iss_step_in  = iss_step_ff;
      if (iss_fire) begin
         if (iss_last) begin
            iss_valid_in = 1'b0;
            iss_step_in  = 2'd0;
         end else begin
            iss_step_in = iss_step_ff + 2'd1;
         end
      end
      if (req_fire) begin
         iss_valid_in = 1'b1;
         iss_step_in  = 2'd0;
      end
      cnt_in = cnt_ff + ((iss_fire && iss_last) ? 2'd1 : 2'd0) - (rsp_fire ? 2'd1 : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_valid_ff <= 1'b0;
         iss_step_ff  <= 2'd0;
         cnt_ff       <= 2'd0;
      end else begin
         iss_valid_ff <= iss_valid_in;
         iss_step_ff  <= iss_step_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         iss_write_ff   <= (req_type == REQ_SAMPLE) ? REQ_SAMPLE : REQ_WRITE;
         iss_wsheet_ff  <= req_sheet_sel;
         iss_addr_ff    <= req_word_addr;
         iss_data_ff    <= req_word_data;
         iss_sheet_b_ff <= iss_sheet_b_in;
         iss_transl_ff  <= mode_flags_ff[MODE_TRANSL];
         iss_u0_ff      <= iss_u0_in;
         iss_u1_ff      <= iss_u1_in;
         iss_v0_ff      <= iss_v0_in;
         iss_v1_ff      <= iss_v1_in;
         iss_uf_ff      <= iss_uf_in;
         iss_vf_ff      <= iss_vf_in;
         iss_tx_ff      <= iss_tx_in;
         iss_ty_ff      <= iss_ty_in;
      end
   end

   // texel address of the current step: 00, 01, 10, 11 as (v, u) corners
   logic [11:0] rd_x, rd_y;
   logic [12:0] rd_x2, rd_y2;
   logic [21:0] rd_off;
   logic [20:0] rd_idx;
   logic        rd_hit;
   logic        wr_hit;

   always_comb begin
      rd_x  = iss_step_ff[0] ? iss_u1_ff : iss_u0_ff;
      rd_y  = iss_step_ff[1] ? iss_v1_ff : iss_v0_ff;
      rd_x2 = 13'(iss_tx_ff) + 13'(rd_x);
      rd_y2 = 13'(iss_ty_ff) + 13'(rd_y);
      // right half of the logical sheet sits below the left half
      if (rd_x2 >= 13'd1024) begin
         rd_x2     = rd_x2 - 13'd1024;
         rd_y2[10] = ~rd_y2[10];
      end
      rd_off = {1'b0, rd_y2[12:1], 9'd0} + 22'(rd_x2[12:1]);
      rd_idx = rd_off[21:1];
      rd_hit = rd_idx < 21'(SHEET_WORDS);
      wr_hit = 19'(iss_addr_ff) < 19'(SHEET_WORDS);
   end

   // ---------------------------------------------------------------- sheet memories
   logic [SHEET_AW-1:0] ram_addr;
   logic                ram_we_a, ram_we_b;
   logic [WORD_W-1:0]   rd_data_a, rd_data_b;

   assign ram_addr = (iss_write_ff == REQ_WRITE) ? iss_addr_ff[SHEET_AW-1:0]
                                                  : rd_idx[SHEET_AW-1:0];
   assign ram_we_a = iss_fire && (iss_write_ff == REQ_WRITE) && wr_hit && !iss_wsheet_ff;
   assign ram_we_b = iss_fire && (iss_write_ff == REQ_WRITE) && wr_hit && iss_wsheet_ff;

   bts_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SHEET_WORDS)
   ) u_sheet_a (
      .clock   (clock),
      .wr_en   (ram_we_a),
      .addr    (ram_addr),
      .wr_data (iss_data_ff),
      .rd_data (rd_data_a)
   );

   bts_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SHEET_WORDS)
   ) u_sheet_b (
      .clock   (clock),
      .wr_en   (ram_we_b),
      .addr    (ram_addr),
      .wr_data (iss_data_ff),
      .rd_data (rd_data_b)
   );

   // ---------------------------------------------------------------- read return
   logic     pend_valid_ff, pend_valid_in;
   pend_type pend_ff, pend_in;

   always_comb begin
      pend_valid_in  = iss_fire;
      pend_in.last   = iss_last;
      pend_in.write  = (iss_write_ff == REQ_WRITE);
      pend_in.sheet_b = iss_sheet_b_ff;
      pend_in.step   = iss_step_ff;
      pend_in.nib    = {rd_off[0], ~rd_y[0], ~rd_x[0]};
      pend_in.hit    = rd_hit;
      pend_in.uf     = iss_uf_ff;
      pend_in.vf     = iss_vf_ff;
      pend_in.transl = iss_transl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

   logic [31:0] rd_word;
   logic [3:0]  rd_nibble;
   logic [7:0]  texel;
   logic [7:0]  t_ff [0:2];

   assign rd_word   = pend_ff.sheet_b ? rd_data_b : rd_data_a;
   assign rd_nibble = rd_word[4*pend_ff.nib +: 4];
   assign texel     = pend_ff.hit ? {rd_nibble, 4'd0} : 8'd0;

   always_ff @(posedge clock) begin
      if (pend_valid_ff && !pend_ff.last) begin
         t_ff[pend_ff.step] <= texel;
      end
   end

   // ---------------------------------------------------------------- first lerp pair
   logic        b1_valid_ff, b1_valid_in;
   logic [23:0] b1_t0x_ff, b1_t0x_in;
   logic [23:0] b1_t1x_ff, b1_t1x_in;
   logic [8:0]  b1_vf_ff, b1_vf_in;
   logic        b1_transl_ff, b1_transl_in;
   logic        b1_arrive;
   logic        out_load;
   logic [23:0] e00, e01, e10, e11;

   assign b1_arrive = pend_valid_ff && pend_ff.last;

   always_comb begin
      e00 = 24'(t_ff[0]);
      e01 = 24'(t_ff[1]);
      e10 = 24'(t_ff[2]);
      e11 = 24'(texel);
      if (pend_ff.transl) begin
         // opaque texels get the opacity lane, clear ones borrow a neighbor
         if (e00 != TEXEL_CLEAR) e00 = e00 | OPAQUE_TAG;
         if (e01 != TEXEL_CLEAR) e01 = e01 | OPAQUE_TAG;
         if (e10 != TEXEL_CLEAR) e10 = e10 | OPAQUE_TAG;
         if (e11 != TEXEL_CLEAR) e11 = e11 | OPAQUE_TAG;
         if (e00 == TEXEL_CLEAR) e00 = 24'(e01[7:0]);
         if (e01 == TEXEL_CLEAR) e01 = 24'(e00[7:0]);
         if (e10 == TEXEL_CLEAR) e10 = 24'(e11[7:0]);
         if (e11 == TEXEL_CLEAR) e11 = 24'(e10[7:0]);
      end
      b1_valid_in  = (b1_valid_ff && !out_load) || b1_arrive;
      b1_t0x_in    = b1_t0x_ff;
      b1_t1x_in    = b1_t1x_ff;
      b1_vf_in     = b1_vf_ff;
      b1_transl_in = b1_transl_ff;
      if (b1_arrive) begin
         if (pend_ff.write) begin
            b1_t0x_in    = 24'd0;
            b1_t1x_in    = 24'd0;
            b1_vf_in     = 9'd0;
            b1_transl_in = 1'b0;
         end else begin
            b1_t0x_in    = blend_lanes(e00, e01, pend_ff.uf);
            b1_t1x_in    = blend_lanes(e10, e11, pend_ff.uf);
            b1_vf_in     = pend_ff.vf;
            b1_transl_in = pend_ff.transl;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= b1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b1_t0x_ff    <= b1_t0x_in;
      b1_t1x_ff    <= b1_t1x_in;
      b1_vf_ff     <= b1_vf_in;
      b1_transl_ff <= b1_transl_in;
   end

   // ---------------------------------------------------------------- second lerp, output
   logic        out_valid_ff, out_valid_in;
   logic [23:0] out_value_ff, out_value_in;
   logic [23:0] f0x, f1x;

   assign out_load = b1_valid_ff && (!out_valid_ff || rsp_ready);

   always_comb begin
      f0x = b1_t0x_ff;
      f1x = b1_t1x_ff;
      if (b1_transl_ff && f0x == TEXEL_CLEAR) f0x = 24'(f1x[7:0]);
      if (b1_transl_ff && f1x == TEXEL_CLEAR) f1x = 24'(f0x[7:0]);
      out_valid_in = out_load || (out_valid_ff && !rsp_ready);
      out_value_in = out_load ? blend_lanes(f0x, f1x, b1_vf_ff) : out_value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff <= out_value_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_texel_value = out_value_ff;

endmodule

// File: design/bts_ram.sv
// bts_ram: single-port synchronous RAM with registered read
`timescale 1ns / 1ps

module bts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule
